// File: sv/cba_pkg.sv
// Shared types, codes and constants of the contiguous block allocator.
package cba_pkg;

   // Defaults of the top level parameters
   localparam int BLOCK_PAYLOAD_DEF = 15;
   localparam int POOL_BYTES_DEF    = 1024;

   // Fixed field widths
   localparam int ALLOC_W  = 16;
   localparam int ADDR_W   = 11;
   localparam int OFFSET_W = 10;
   localparam int STATUS_W = 3;
   localparam int HDR_W    = 8;
   localparam int LEN_W    = 7;

   // Header layout: in-use flag on top, run length below
   localparam logic [HDR_W-1:0] USED_FLAG = 8'd128;
   localparam logic [LEN_W-1:0] LEN_MAX   = 7'd127;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK           = 3'd0,
      STAT_NO_SPACE     = 3'd1,
      STAT_TOO_LARGE    = 3'd2,
      STAT_OUT_OF_RANGE = 3'd3,
      STAT_ALREADY_FREE = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_CHECK,
      S_HEAD,
      S_RUN,
      S_FREE_HEAD,
      S_FREE_CLR,
      S_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_SCAN_START,
      OP_FREE_START,
      OP_SKIP,
      OP_EXTEND,
      OP_RESTART,
      OP_ALLOC_OK,
      OP_FREE_GO,
      OP_FREE_CLR
   } op_type;

   // Controller to datapath
   typedef struct packed {
      op_type     op;
      logic       in_run;
      logic       finish;
      status_type status;
      logic       rsp_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic div_done;
      logic mode_free;
      logic free_bad;
      logic too_large;
      logic no_blocks;
      logic hdr_used;
      logic head_over;
      logic cand_full;
      logic cand_end;
      logic cand_over;
      logic free_last;
   } stat_type;

endpackage

// File: sv/cba_req_if.sv
// Request channel: allocate or free transaction with valid/ready handshake.
interface cba_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [15:0] alloc_bytes;
   logic [10:0] address;

   modport source (output valid, output mode, output alloc_bytes, output address, input ready);
   modport sink (input valid, input mode, input alloc_bytes, input address, output ready);
endinterface

// File: sv/cba_rsp_if.sv
// Response channel: status and payload offset with valid/ready handshake.
interface cba_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [9:0] payload_offset;

   modport source (output valid, output status, output payload_offset, input ready);
   modport sink (input valid, input status, input payload_offset, output ready);
endinterface

// File: sv/contiguous_block_allocator.sv
// Next-fit contiguous block allocator over a pool of fixed-stride block headers.
// Allocate: divide by the stride, check, then one header read per cycle during the scan, and
// the result load; at most about 2*NBLK reads for a full pass.
// Free: divide, check, header read, then the run is cleared one block per cycle (run length up to 127).
// One transaction at a time; the response register lets the next request in while it waits.
// Reset (synchronous): headers are cleared by a sweep over every block, requests held off meanwhile.
module contiguous_block_allocator #(
   parameter int BLOCK_PAYLOAD = cba_pkg::BLOCK_PAYLOAD_DEF,
   parameter int POOL_BYTES    = cba_pkg::POOL_BYTES_DEF
) (
   input logic         clock,
   input logic         reset,
   cba_req_if.sink     req_bus,
   cba_rsp_if.source   rsp_bus
);
   import cba_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cba_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   cba_datapath #(
      .BLOCK_PAYLOAD (BLOCK_PAYLOAD),
      .POOL_BYTES    (POOL_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_mode           (req_bus.mode),
      .req_alloc_bytes    (req_bus.alloc_bytes),
      .req_address        (req_bus.address),
      .rsp_status         (rsp_bus.status),
      .rsp_payload_offset (rsp_bus.payload_offset)
   );

endmodule

// File: sv/cba_divider.sv
// Division by the block stride: reciprocal multiply, then remainder, each in its own registered step.
module cba_divider #(
   parameter int STRIDE = cba_pkg::BLOCK_PAYLOAD_DEF + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cba_pkg::ALLOC_W-1:0]   numer,
   output logic                          done,
   output logic [cba_pkg::ALLOC_W-1:0]   quot,
   output logic [$clog2(STRIDE+1)-1:0]   rem
);
   import cba_pkg::*;

   localparam int SW    = $clog2(STRIDE + 1);
   localparam int LG    = $clog2(STRIDE);
   localparam int SHIFT = ALLOC_W + LG;
   localparam int MW    = ALLOC_W + 1;
   localparam int PRW   = ALLOC_W + MW;
   localparam int BKW   = ALLOC_W + SW;
   // ceil(2^SHIFT / STRIDE): exact quotient for every 16-bit numerator
   localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(STRIDE) - longint'(1)) /
                              longint'(STRIDE);
   localparam logic [MW-1:0]  RECIP_C  = MW'(RECIP);
   localparam logic [BKW-1:0] STRIDE_C = BKW'(STRIDE);

   logic [1:0]         step_ff, step_in;
   logic [ALLOC_W-1:0] num_ff, num_in;
   logic [ALLOC_W-1:0] quot_ff, quot_in;
   logic [SW-1:0]      rem_ff, rem_in;
   logic [PRW-1:0]     prod;
   logic [BKW-1:0]     back;
   logic [ALLOC_W-1:0] diff;

   // Quotient in the first step, remainder in the second
   always_comb begin
      prod    = PRW'(num_ff) * PRW'(RECIP_C);
      back    = BKW'(quot_ff) * STRIDE_C;
      diff    = num_ff - back[ALLOC_W-1:0];
      step_in = {step_ff[0], 1'b0};
      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start) begin
         step_in = 2'b01;
         num_in  = numer;
      end
      if (step_ff[0]) begin
         quot_in = ALLOC_W'(prod >> SHIFT);
      end
      if (step_ff[1]) begin
         rem_in = diff[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done = step_ff == 2'b00;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// File: sv/cba_datapath.sv
// Datapath: header memory, scan counters, search pointer and result registers.
module cba_datapath #(
   parameter int BLOCK_PAYLOAD = cba_pkg::BLOCK_PAYLOAD_DEF,
   parameter int POOL_BYTES    = cba_pkg::POOL_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cba_pkg::cmd_type               cmd,
   output cba_pkg::stat_type              stat,
   input  logic                           req_mode,
   input  logic [cba_pkg::ALLOC_W-1:0]    req_alloc_bytes,
   input  logic [cba_pkg::ADDR_W-1:0]     req_address,
   output logic [cba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [cba_pkg::OFFSET_W-1:0]   rsp_payload_offset
);
   import cba_pkg::*;

   localparam int STRIDE = BLOCK_PAYLOAD + 1;
   localparam int NBLK   = POOL_BYTES / STRIDE;
   localparam int NSLOT  = (NBLK > 0) ? NBLK : 1;
   localparam int BW     = (NSLOT > 1) ? $clog2(NSLOT) : 1;
   localparam int CW     = $clog2(NSLOT + 1);
   localparam int SCW    = $clog2(NSLOT + int'(LEN_MAX) + 1);
   localparam int SW     = $clog2(STRIDE + 1);
   localparam int PW     = (BW + SW > OFFSET_W) ? BW + SW : OFFSET_W;
   localparam logic [CW-1:0]  NBLK_C = CW'(NBLK);
   localparam logic [SCW-1:0] NBLK_S = SCW'(NBLK);
   localparam logic [BW-1:0]  LAST_BLK = BW'(NSLOT - 1);

   // Header store
   logic [HDR_W-1:0] hdr_mem [NSLOT];
   logic [HDR_W-1:0] rd_ff;
   logic             wr_en;
   logic [BW-1:0]    wr_addr;
   logic [HDR_W-1:0] wr_data;
   logic [BW-1:0]    rd_addr;

   // Control registers
   logic [BW-1:0]  clr_ff, clr_in;
   logic [BW-1:0]  sp_ff, sp_in;

   // Transaction registers
   logic                mode_ff, mode_in;
   logic                addr_zero_ff, addr_zero_in;
   logic [LEN_W-1:0]    need_ff, need_in;
   logic [BW-1:0]       p_ff, p_in;
   logic [CW-1:0]       q_ff, q_in;
   logic [LEN_W-1:0]    c_ff, c_in;
   logic [SCW-1:0]      scanned_ff, scanned_in;
   logic [LEN_W-1:0]    cnt_ff, cnt_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [OFFSET_W-1:0] res_offset_ff, res_offset_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;

   // Divider
   logic               div_done;
   logic [ALLOC_W-1:0] div_numer;
   logic [ALLOC_W-1:0] quot;
   logic [SW-1:0]      rem;

   // Scan arithmetic
   logic             hdr_used;
   logic [LEN_W-1:0] hdr_len;
   logic [SCW-1:0]   head_sum;
   logic [SCW-1:0]   p_sum;
   logic [SCW-1:0]   p_wrap;
   logic [BW-1:0]    head_p;
   logic [LEN_W-1:0] cand_c;
   logic [CW-1:0]    cand_q;
   logic             cand_end;
   logic [BW-1:0]    new_p;
   logic [SCW-1:0]   stop_sum;
   logic [BW-1:0]    blk;
   logic [PW-1:0]    off_full;

   assign div_numer = (req_mode == MODE_FREE) ?
                      (ALLOC_W'(req_address) - ALLOC_W'(1)) : req_alloc_bytes;

   cba_divider #(
      .STRIDE (STRIDE)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == OP_LOAD),
      .numer (div_numer),
      .done  (div_done),
      .quot  (quot),
      .rem   (rem)
   );

   // Header decode and skip target
   always_comb begin
      hdr_used = |(rd_ff & USED_FLAG);
      hdr_len  = (rd_ff[LEN_W-1:0] == '0) ? LEN_W'(1) : rd_ff[LEN_W-1:0];
      head_sum = scanned_ff + SCW'(hdr_len);
      p_sum    = SCW'(p_ff) + SCW'(hdr_len);
      p_wrap   = (p_sum >= NBLK_S) ? (p_sum - NBLK_S) : p_sum;
      head_p   = p_wrap[BW-1:0];
      blk      = quot[BW-1:0];
      off_full = PW'(p_ff) * PW'(STRIDE) + PW'(1);
   end

   // Candidate run: first free block, or one more block of a run in progress
   always_comb begin
      if (!cmd.in_run) begin
         cand_c = LEN_W'(1);
         cand_q = CW'(p_ff) + CW'(1);
      end else if (hdr_used) begin
         cand_c = c_ff;
         cand_q = q_ff;
      end else begin
         cand_c = c_ff + LEN_W'(1);
         cand_q = q_ff + CW'(1);
      end
      cand_end = cand_q >= NBLK_C;
      new_p    = cand_end ? '0 : cand_q[BW-1:0];
      stop_sum = scanned_ff + SCW'(cand_c);
   end

   // Status to the controller
   always_comb begin
      stat.clear_last = clr_ff == LAST_BLK;
      stat.div_done   = div_done;
      stat.mode_free  = mode_ff;
      stat.free_bad   = addr_zero_ff | (rem != '0) |
                        ({1'b0, quot} >= (ALLOC_W + 1)'(NBLK));
      stat.too_large  = quot >= ALLOC_W'(LEN_MAX);
      stat.no_blocks  = (NBLK == 0);
      stat.hdr_used   = hdr_used;
      stat.head_over  = head_sum >= NBLK_S;
      stat.cand_full  = cand_c == need_ff;
      stat.cand_end   = cand_end;
      stat.cand_over  = stop_sum >= NBLK_S;
      stat.free_last  = (cnt_ff == LEN_W'(1)) | (p_ff == LAST_BLK);
   end

   // Next values per command
   always_comb begin
      clr_in        = clr_ff;
      sp_in         = sp_ff;
      mode_in       = mode_ff;
      addr_zero_in  = addr_zero_ff;
      need_in       = need_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      c_in          = c_ff;
      scanned_in    = scanned_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_offset_in = res_offset_ff;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      wr_en         = 1'b0;
      wr_addr       = p_ff;
      wr_data       = '0;
      rd_addr       = p_ff;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
         end
         OP_LOAD: begin
            mode_in      = req_mode;
            addr_zero_in = req_address == '0;
         end
         OP_SCAN_START: begin
            p_in       = sp_ff;
            scanned_in = '0;
            need_in    = quot[LEN_W-1:0] + LEN_W'(1);
            rd_addr    = sp_ff;
         end
         OP_FREE_START: begin
            p_in    = blk;
            rd_addr = blk;
         end
         OP_SKIP: begin
            p_in       = head_p;
            scanned_in = head_sum;
            rd_addr    = head_p;
         end
         OP_EXTEND: begin
            c_in    = cand_c;
            q_in    = cand_q;
            rd_addr = cand_q[BW-1:0];
         end
         OP_RESTART: begin
            p_in       = new_p;
            scanned_in = stop_sum;
            rd_addr    = new_p;
         end
         OP_ALLOC_OK: begin
            wr_en   = 1'b1;
            wr_addr = p_ff;
            wr_data = USED_FLAG | HDR_W'(need_ff);
            sp_in   = new_p;
         end
         OP_FREE_GO: begin
            cnt_in = hdr_len;
         end
         OP_FREE_CLR: begin
            wr_en   = 1'b1;
            wr_addr = p_ff;
            p_in    = p_ff + 1'b1;
            cnt_in  = cnt_ff - 1'b1;
         end
         default: begin
         end
      endcase
      // Result of the transaction
      if (cmd.finish) begin
         res_status_in = STATUS_W'(cmd.status);
         res_offset_in = (cmd.op == OP_ALLOC_OK) ? off_full[OFFSET_W-1:0] : '0;
      end
      // Output register
      if (cmd.rsp_load) begin
         rsp_status_in = res_status_ff;
         rsp_offset_in = res_offset_ff;
      end
   end

   // Header memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem[wr_addr] <= wr_data;
      end
      rd_ff <= hdr_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         sp_ff  <= '0;
      end else begin
         clr_ff <= clr_in;
         sp_ff  <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      addr_zero_ff  <= addr_zero_in;
      need_ff       <= need_in;
      p_ff          <= p_in;
      q_ff          <= q_in;
      c_ff          <= c_in;
      scanned_ff    <= scanned_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_offset_ff <= res_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_offset_ff;

endmodule

// File: sv/cba_controller.sv
// Controller: sequences clearing, division, next-fit scan and run freeing.
module cba_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cba_pkg::cmd_type  cmd,
   input  cba_pkg::stat_type stat
);
   import cba_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      go_stop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '{op: OP_NONE, in_run: 1'b0, finish: 1'b0, status: STAT_OK,
                    rsp_load: 1'b0};
      req_ready = 1'b0;
      go_stop   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.mode_free) begin
               if (stat.free_bad) begin
                  cmd.finish = 1'b1;
                  cmd.status = STAT_OUT_OF_RANGE;
                  state_in   = S_DONE;
               end else begin
                  cmd.op   = OP_FREE_START;
                  state_in = S_FREE_HEAD;
               end
            end else begin
               priority if (stat.too_large) begin
                  cmd.finish = 1'b1;
                  cmd.status = STAT_TOO_LARGE;
                  state_in   = S_DONE;
               end else if (stat.no_blocks) begin
                  cmd.finish = 1'b1;
                  cmd.status = STAT_NO_SPACE;
                  state_in   = S_DONE;
               end else begin
                  cmd.op   = OP_SCAN_START;
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD, S_RUN: begin
            cmd.in_run = state_ff == S_RUN;
            priority if (stat.hdr_used) begin
               if (state_ff == S_RUN) begin
                  go_stop = 1'b1;
               end else if (stat.head_over) begin
                  cmd.finish = 1'b1;
                  cmd.status = STAT_NO_SPACE;
                  state_in   = S_DONE;
               end else begin
                  cmd.op   = OP_SKIP;
                  state_in = S_HEAD;
               end
            end else if (stat.cand_full) begin
               cmd.op     = OP_ALLOC_OK;
               cmd.finish = 1'b1;
               cmd.status = STAT_OK;
               state_in   = S_DONE;
            end else if (stat.cand_end) begin
               go_stop = 1'b1;
            end else begin
               cmd.op   = OP_EXTEND;
               state_in = S_RUN;
            end
            // Candidate run broken: count it and go on after it
            if (go_stop) begin
               if (stat.cand_over) begin
                  cmd.finish = 1'b1;
                  cmd.status = STAT_NO_SPACE;
                  state_in   = S_DONE;
               end else begin
                  cmd.op   = OP_RESTART;
                  state_in = S_HEAD;
               end
            end
         end
         S_FREE_HEAD: begin
            if (!stat.hdr_used) begin
               cmd.finish = 1'b1;
               cmd.status = STAT_ALREADY_FREE;
               state_in   = S_DONE;
            end else begin
               cmd.op   = OP_FREE_GO;
               state_in = S_FREE_CLR;
            end
         end
         S_FREE_CLR: begin
            cmd.op = OP_FREE_CLR;
            if (stat.free_last) begin
               cmd.finish = 1'b1;
               cmd.status = STAT_OK;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // Output register valid
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
